FILE: design/dws_pkg.sv
package dws_pkg;

  // Default number of entries in the deque
  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 32;

  // Operation codes
  localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
  localparam logic [1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [1:0] OP_FIND       = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Shift controls broadcast to every cell of the row
  typedef struct packed {
    logic shift_r;  // push at front: every entry moves one place back
    logic shift_l;  // pop at front: every entry moves one place forward
  } cell_ctl_t;

endpackage

FILE: design/dws_cell.sv
module dws_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  dws_pkg::cell_ctl_t                ctl,
  input  logic                              load,
  input  logic signed [dws_pkg::WORD_W-1:0] din,
  input  logic signed [dws_pkg::WORD_W-1:0] left,
  input  logic signed [dws_pkg::WORD_W-1:0] right,
  input  logic signed [dws_pkg::WORD_W-1:0] key,
  input  logic                              occ,
  input  logic                              tok_in,
  input  logic                              hit_in,
  output logic signed [dws_pkg::WORD_W-1:0] entry,
  output logic                              tok,
  output logic                              hit
);
  import dws_pkg::*;

  // Hold, shift or load the stored entry
  always_ff @(posedge clk) begin
    if (ctl.shift_r) begin
      entry <= left;
    end else if (ctl.shift_l) begin
      entry <= right;
    end else if (load) begin
      entry <= din;
    end
  end

  // Advance the search token one cell per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else begin
      tok <= tok_in;
    end
  end

  // Fold this cell's compare into the running match flag as the token passes
  always_ff @(posedge clk) begin
    if (tok_in) begin
      hit <= hit_in | (occ && (entry == key));
    end
  end

endmodule

FILE: design/deque_with_search.sv
// Channel  | Ports                            | Beat taken when
// ---------+----------------------------------+-------------------------
// command  | start, op, value, busy           | start high, busy low
// result   | strobe, status, data, found      | every cycle strobe is high
//
// Insert and remove: result beat on the cycle after the command beat;
// a new command may follow at once, one per cycle.
// Search: the key token walks the row of DEPTH cells one cell per cycle,
// and the result beat follows once the token leaves the last cell; busy
// is high until then. Reset (rst, synchronous) empties the deque.
// The receiver cannot stall; every result beat is taken as shown.
module deque_with_search #(
  parameter int DEPTH = dws_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [1:0]                        op,
  input  logic signed [dws_pkg::WORD_W-1:0] value,
  output logic                              busy,
  output logic                              strobe,
  output logic [1:0]                        status,
  output logic signed [dws_pkg::WORD_W-1:0] data,
  output logic                              found
);
  import dws_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]         count;
  logic                     go;
  logic signed [WORD_W-1:0] key;

  logic                     accept;
  logic                     full;
  logic                     empty;
  logic                     do_pf;
  logic                     do_pb;
  logic                     do_pop;
  cell_ctl_t                ctl;

  logic signed [WORD_W-1:0] entry [DEPTH];
  logic                     tok   [DEPTH];
  logic                     hit   [DEPTH];

  // Decode the command beat
  assign accept = start && !busy;
  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign do_pf  = accept && (op == OP_PUSH_FRONT) && !full;
  assign do_pb  = accept && (op == OP_PUSH_BACK) && !full;
  assign do_pop = accept && (op == OP_POP_FRONT) && !empty;

  assign ctl.shift_r = do_pf;
  assign ctl.shift_l = do_pop;

  // Row of cells, front entry in cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] left;
    logic signed [WORD_W-1:0] right;
    logic                     tok_in;
    logic                     hit_in;

    if (i == 0) begin : g_head
      assign left   = value;
      assign tok_in = go;
      assign hit_in = 1'b0;
    end else begin : g_body
      assign left   = entry[i-1];
      assign tok_in = tok[i-1];
      assign hit_in = hit[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right = '0;
    end else begin : g_mid
      assign right = entry[i+1];
    end

    dws_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .load   (do_pb && (count == CNT_W'(i))),
      .din    (value),
      .left   (left),
      .right  (right),
      .key    (key),
      .occ    (CNT_W'(i) < count),
      .tok_in (tok_in),
      .hit_in (hit_in),
      .entry  (entry[i]),
      .tok    (tok[i]),
      .hit    (hit[i])
    );
  end

  // Track the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (do_pf || do_pb) begin
      count <= count + CNT_W'(1);
    end else if (do_pop) begin
      count <= count - CNT_W'(1);
    end
  end

  // Launch a search and hold off commands until the token leaves the row
  always_ff @(posedge clk) begin
    if (rst) begin
      go   <= 1'b0;
      busy <= 1'b0;
    end else begin
      go <= accept && (op == OP_FIND);
      if (accept && (op == OP_FIND)) begin
        busy <= 1'b1;
      end else if (tok[DEPTH-1]) begin
        busy <= 1'b0;
      end
    end
  end

  // Capture the key
  always_ff @(posedge clk) begin
    if (accept && (op == OP_FIND)) begin
      key <= value;
    end
  end

  // Drive the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (accept && (op != OP_FIND)) || tok[DEPTH-1];
    end
  end

  // Form the result beat
  always_ff @(posedge clk) begin
    if (tok[DEPTH-1]) begin
      status <= ST_OK;
      found  <= hit[DEPTH-1];
      data   <= hit[DEPTH-1] ? key : '0;
    end else if (accept) begin
      found <= 1'b0;
      case (op)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          status <= full ? ST_FULL : ST_OK;
          data   <= '0;
        end
        OP_POP_FRONT: begin
          status <= empty ? ST_EMPTY : ST_OK;
          data   <= empty ? -WORD_W'(1) : entry[0];
        end
        default: begin
          status <= ST_OK;
          data   <= '0;
        end
      endcase
    end
  end

endmodule

FILE: design/dws_check.sv
module dws_check (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic [1:0]                        op,
  input logic signed [dws_pkg::WORD_W-1:0] value,
  input logic                              busy,
  input logic                              strobe,
  input logic [1:0]                        status,
  input logic signed [dws_pkg::WORD_W-1:0] data,
  input logic                              found
);
  import dws_pkg::*;

  // Insert and remove answer on the very next cycle
  a_quick_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (op != OP_FIND)) |=> strobe)
    else $error("insert or remove gave no result on the next cycle");

  // Search holds off further commands
  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (op == OP_FIND)) |=> (busy && !strobe))
    else $error("search did not raise busy");

  // A hit comes back with an ok status (the data term passes whenever busy is low)
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (strobe && found) |-> ((status == ST_OK) && (data == $past(value, 1) || busy == 1'b0)))
    else $error("found result with bad status");

  // Empty remove returns all ones
  a_empty_data: assert property (@(posedge clk) disable iff (rst)
    (strobe && (status == ST_EMPTY)) |-> ((data == -WORD_W'(1)) && !found))
    else $error("empty remove with wrong data");

  // Full insert returns zero
  a_full_data: assert property (@(posedge clk) disable iff (rst)
    (strobe && (status == ST_FULL)) |-> ((data == '0) && !found))
    else $error("full insert with wrong data");

endmodule

bind deque_with_search dws_check u_dws_check (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .op     (op),
  .value  (value),
  .busy   (busy),
  .strobe (strobe),
  .status (status),
  .data   (data),
  .found  (found)
);

FILE: tb/deque_with_search_tb.sv
module deque_with_search_tb;
  import dws_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 600;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RECENT_MAX   = 24;

  typedef struct {
    logic [1:0]               op;
    logic signed [WORD_W-1:0] value;
    int                       gap;
  } deque_cmd_t;

  typedef struct {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] data;
    logic                     found;
  } deque_res_t;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic [1:0]               op = OP_PUSH_FRONT;
  logic signed [WORD_W-1:0] value = '0;
  logic                     busy;
  logic                     strobe;
  logic [1:0]               status;
  logic signed [WORD_W-1:0] data;
  logic                     found;

  deque_cmd_t               cmd_q[$];
  deque_res_t               due_results[$];
  logic signed [WORD_W-1:0] recent_vals[$];

  // predicted deque contents
  logic signed [WORD_W-1:0] ring [DEPTH];
  int                       head = 0;
  int                       occupancy = 0;

  bit no_idle = 1'b0;
  int fail_cnt = 0;
  int checked_cnt = 0;
  int insert_cnt = 0;
  int remove_cnt = 0;
  int search_cnt = 0;
  int full_cnt = 0;
  int empty_cnt = 0;
  int hit_cnt = 0;
  int cycle_cnt = 0;

  deque_with_search #(.DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .op     (op),
    .value  (value),
    .busy   (busy),
    .strobe (strobe),
    .status (status),
    .data   (data),
    .found  (found)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0d] mismatch: %s", cycle_cnt, msg);
    fail_cnt++;
  endtask

  // Apply one command to the predicted deque and queue the result it gives
  task automatic advance_deque(input logic [1:0] cmd_op, input logic signed [WORD_W-1:0] arg);
    deque_res_t res;
    res = '{status: ST_OK, data: '0, found: 1'b0};
    case (cmd_op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        insert_cnt++;
        if (occupancy == DEPTH) begin
          res.status = ST_FULL;
          full_cnt++;
        end else if (cmd_op == OP_PUSH_FRONT) begin
          head = (head + DEPTH - 1) % DEPTH;
          ring[head] = arg;
          occupancy++;
        end else begin
          ring[(head + occupancy) % DEPTH] = arg;
          occupancy++;
        end
      end
      OP_POP_FRONT: begin
        remove_cnt++;
        if (occupancy == 0) begin
          res.status = ST_EMPTY;
          res.data = -1;
          empty_cnt++;
        end else begin
          res.data = ring[head];
          head = (head + 1) % DEPTH;
          occupancy--;
        end
      end
      default: begin
        // scan from the front, first match wins
        search_cnt++;
        for (int i = 0; i < occupancy && !res.found; i++) begin
          if (ring[(head + i) % DEPTH] == arg) begin
            res.found = 1'b1;
            res.data = arg;
          end
        end
        if (res.found) hit_cnt++;
      end
    endcase
    due_results.push_back(res);
  endtask

  // Queue one command with its idle gap; long runs go without gaps
  task automatic add_cmd(input logic [1:0] cmd_op, input logic signed [WORD_W-1:0] arg);
    deque_cmd_t cmd;
    if ($urandom_range(0, 11) == 0) no_idle = !no_idle;
    cmd.op = cmd_op;
    cmd.value = arg;
    cmd.gap = no_idle ? 0 : $urandom_range(0, 7);
    cmd_q.push_back(cmd);
    if (cmd_op == OP_PUSH_FRONT || cmd_op == OP_PUSH_BACK) begin
      recent_vals.push_back(arg);
      if (recent_vals.size() > RECENT_MAX) void'(recent_vals.pop_front());
    end
  endtask

  function automatic logic signed [WORD_W-1:0] pick_value();
    logic signed [WORD_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'h7FFF_FFFF;
      1: v = 32'h8000_0000;
      2: v = $urandom_range(0, 1) ? -1 : 0;
      3, 4: v = $urandom_range(0, 15);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Empty cases, extremes, ring wrap, duplicates, then fill to full and insert past it
  task automatic build_directed();
    add_cmd(OP_POP_FRONT, 32'h1234_5678);
    add_cmd(OP_FIND, 0);
    add_cmd(OP_PUSH_BACK, 32'h7FFF_FFFF);
    add_cmd(OP_PUSH_FRONT, 32'h8000_0000);
    add_cmd(OP_PUSH_BACK, 0);
    add_cmd(OP_PUSH_FRONT, -1);
    add_cmd(OP_PUSH_BACK, 123);
    add_cmd(OP_PUSH_BACK, 123);
    add_cmd(OP_FIND, 32'h8000_0000);
    add_cmd(OP_FIND, 123);
    add_cmd(OP_FIND, 5);
    add_cmd(OP_POP_FRONT, 0);
    for (int i = 0; i < 11; i++) begin
      add_cmd(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK,
              i[0] ? (32'hAAAA_AAAA ^ i) : (32'h5555_5555 ^ i));
    end
    add_cmd(OP_PUSH_BACK, 32'h0BAD_0BAD);
    add_cmd(OP_PUSH_FRONT, 32'h0BAD_0BAD);
    add_cmd(OP_FIND, 32'h5555_5555);
  endtask

  // Runs that lean towards filling, draining or an even mix
  task automatic build_random();
    op_mix_t                  mix;
    int                       run_left;
    int                       roll;
    logic [1:0]               cmd_op;
    logic signed [WORD_W-1:0] arg;
    mix = MIX_EVEN;
    run_left = 0;
    repeat (RANDOM_ITEMS) begin
      if (run_left == 0) begin
        mix = op_mix_t'($urandom_range(0, 2));
        run_left = $urandom_range(10, 40);
      end
      run_left--;
      roll = $urandom_range(0, 99);
      case (mix)
        MIX_FILL:
          cmd_op = (roll < 70) ? (roll[0] ? OP_PUSH_FRONT : OP_PUSH_BACK) :
                   (roll < 85) ? OP_POP_FRONT : OP_FIND;
        MIX_DRAIN:
          cmd_op = (roll < 20) ? (roll[0] ? OP_PUSH_FRONT : OP_PUSH_BACK) :
                   (roll < 75) ? OP_POP_FRONT : OP_FIND;
        default:
          cmd_op = (roll < 25) ? OP_PUSH_FRONT : (roll < 50) ? OP_PUSH_BACK :
                   (roll < 75) ? OP_POP_FRONT : OP_FIND;
      endcase
      if (cmd_op == OP_FIND && recent_vals.size() != 0 && $urandom_range(0, 99) < 65)
        arg = recent_vals[$urandom_range(0, recent_vals.size() - 1)];
      else
        arg = pick_value();
      add_cmd(cmd_op, arg);
    end
  endtask

  // Command driver: hold a beat while busy, otherwise count down the gap
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        advance_deque(op, value);
        void'(cmd_q.pop_front());
      end
      if (start && busy) begin
        // hold the pending beat
      end else if (cmd_q.size() != 0 && cmd_q[0].gap == 0) begin
        start <= 1'b1;
        op    <= cmd_q[0].op;
        value <= cmd_q[0].value;
      end else begin
        start <= 1'b0;
        op    <= 2'($urandom);
        value <= $urandom;
        if (cmd_q.size() != 0) cmd_q[0].gap = cmd_q[0].gap - 1;
      end
    end
  end

  // Result monitor: take every strobed beat against the oldest prediction
  always @(posedge clk) begin
    deque_res_t exp_res;
    if (!rst && strobe === 1'b1) begin
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d data=%0d found=%0d",
                                  status, data, found));
      end else begin
        exp_res = due_results.pop_front();
        checked_cnt++;
        if (status !== exp_res.status)
          report_mismatch($sformatf("status %0d, want %0d", status, exp_res.status));
        if (data !== exp_res.data)
          report_mismatch($sformatf("data %0d, want %0d", data, exp_res.data));
        if (found !== exp_res.found)
          report_mismatch($sformatf("found %0d, want %0d", found, exp_res.found));
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    build_directed();
    build_random();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (cmd_q.size() != 0 || due_results.size() != 0) @(posedge clk);
    // let a stray late beat show up before closing
    repeat (DEPTH + 4) @(posedge clk);
    $display("ran %0d inserts, %0d removes and %0d searches; %0d results checked",
             insert_cnt, remove_cnt, search_cnt, checked_cnt);
    $display("saw %0d inserts on a full deque, %0d removes on an empty one, %0d search hits",
             full_cnt, empty_cnt, hit_cnt);
    if (fail_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
